// ===== sv/jbt_pkg.sv =====
// Shared types, character constants and token codes of the JSON byte tokenizer.
// Used by jbt_lexer, jbt_out_buf and json_byte_tokenizer_unit; depends on nothing.
`default_nettype none

package jbt_pkg;

    localparam int MaxResults = 3;

    localparam logic [3:0] K_LBRACE   = 4'd0;
    localparam logic [3:0] K_LBRACKET = 4'd1;
    localparam logic [3:0] K_RBRACE   = 4'd2;
    localparam logic [3:0] K_RBRACKET = 4'd3;
    localparam logic [3:0] K_COLON    = 4'd4;
    localparam logic [3:0] K_COMMA    = 4'd5;
    localparam logic [3:0] K_STRING   = 4'd6;
    localparam logic [3:0] K_INTEGER  = 4'd7;
    localparam logic [3:0] K_DECIMAL  = 4'd8;
    localparam logic [3:0] K_BOOLEAN  = 4'd9;
    localparam logic [3:0] K_NULL     = 4'd10;
    localparam logic [3:0] K_EOF      = 4'd11;
    localparam logic [3:0] K_ILLEGAL  = 4'd12;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_STRING  = 2'd1;
    localparam logic [1:0] MODE_NUMBER  = 2'd2;
    localparam logic [1:0] MODE_KEYWORD = 2'd3;

    localparam logic [2:0] PH_SIGN       = 3'd0;
    localparam logic [2:0] PH_ZERO       = 3'd1;
    localparam logic [2:0] PH_INT        = 3'd2;
    localparam logic [2:0] PH_FRAC_START = 3'd3;
    localparam logic [2:0] PH_FRAC       = 3'd4;
    localparam logic [2:0] PH_EXP_START  = 3'd5;
    localparam logic [2:0] PH_EXP_SIGN   = 3'd6;
    localparam logic [2:0] PH_EXP        = 3'd7;

    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;
    localparam logic [1:0] KW_NONE  = 2'd3;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_UPPER_E  = 8'h45;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_S        = 8'h73;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       lit;
        logic       done;
    } t_result;

    typedef struct packed {
        t_result [MaxResults-1:0] res;
        logic [1:0]               cnt;
    } t_res_set;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] phase;
        logic       seen_dec;
        logic [2:0] kw_pos;
        logic [1:0] kw_which;
        logic       kw_match;
    } t_lex_state;

    localparam t_lex_state LEX_IDLE = '{
        mode: MODE_IDLE, phase: PH_SIGN, seen_dec: 1'b0,
        kw_pos: 3'd0, kw_which: KW_TRUE, kw_match: 1'b1
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_struct(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_LBRACKET) || (b == CH_RBRACE) ||
               (b == CH_RBRACKET) || (b == CH_COLON) || (b == CH_COMMA);
    endfunction

    function automatic logic [3:0] struct_kind(input logic [7:0] b);
        logic [3:0] k;
        priority case (b)
            CH_LBRACE:   k = K_LBRACE;
            CH_LBRACKET: k = K_LBRACKET;
            CH_RBRACE:   k = K_RBRACE;
            CH_RBRACKET: k = K_RBRACKET;
            CH_COLON:    k = K_COLON;
            default:     k = K_COMMA;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] which, input logic [2:0] pos);
        logic [7:0] c;
        priority case ({which, pos})
            {KW_TRUE, 3'd0}:  c = CH_T;
            {KW_TRUE, 3'd1}:  c = CH_R;
            {KW_TRUE, 3'd2}:  c = CH_U;
            {KW_TRUE, 3'd3}:  c = CH_E;
            {KW_FALSE, 3'd0}: c = CH_F;
            {KW_FALSE, 3'd1}: c = CH_A;
            {KW_FALSE, 3'd2}: c = CH_L;
            {KW_FALSE, 3'd3}: c = CH_S;
            {KW_FALSE, 3'd4}: c = CH_E;
            {KW_NULL, 3'd0}:  c = CH_N;
            {KW_NULL, 3'd1}:  c = CH_U;
            {KW_NULL, 3'd2}:  c = CH_L;
            {KW_NULL, 3'd3}:  c = CH_L;
            default:          c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] which);
        return (which == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

endpackage

`default_nettype wire

// ===== sv/jbt_lexer.sv =====
// Combinational lexer step: next lexer state and up to two results for one byte.
// Depends on jbt_pkg.
`default_nettype none

module jbt_lexer
    import jbt_pkg::*;
(
    input  t_lex_state i_state,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    output t_lex_state o_state,
    output t_res_set   o_set
);

    always_comb begin
        t_lex_state s;
        t_result [MaxResults-1:0] res;
        logic [1:0] n;
        logic       ok;
        logic [2:0] nph;
        logic       miss;
        logic       match_n;
        logic [2:0] pos_n;
        logic [3:0] kw_kind;

        s       = i_state;
        res     = '0;
        n       = 2'd0;
        ok      = 1'b0;
        nph     = i_state.phase;
        miss    = 1'b0;
        match_n = 1'b0;
        pos_n   = 3'd0;
        kw_kind = (i_state.kw_which == KW_NULL) ? K_NULL : K_BOOLEAN;

        unique case (i_state.mode)
            MODE_STRING: begin
                if (i_byte == CH_QUOTE) begin
                    res[n] = '{kind: K_STRING, data: CH_NUL, lit: 1'b0, done: 1'b1};
                    n = n + 2'd1;
                    s = LEX_IDLE;
                end else if (i_byte == CH_NUL) begin
                    res[n] = '{kind: K_ILLEGAL, data: CH_NUL, lit: 1'b0, done: 1'b1};
                    n = n + 2'd1;
                    s = LEX_IDLE;
                end else begin
                    res[n] = '{kind: K_STRING, data: i_byte, lit: 1'b1, done: 1'b0};
                    n = n + 2'd1;
                end
            end
            MODE_NUMBER: begin
                if (i_byte == CH_NUL) begin
                    res[n] = '{kind: K_ILLEGAL, data: CH_NUL, lit: 1'b0, done: 1'b1};
                    n = n + 2'd1;
                    s = LEX_IDLE;
                end else if ((is_struct(i_byte) && i_byte != CH_LBRACE &&
                              i_byte != CH_LBRACKET && i_byte != CH_COLON ||
                              is_ws(i_byte)) &&
                             (i_state.phase == PH_ZERO || i_state.phase == PH_INT ||
                              i_state.phase == PH_FRAC || i_state.phase == PH_EXP)) begin
                    res[n] = '{kind: i_state.seen_dec ? K_DECIMAL : K_INTEGER,
                               data: CH_NUL, lit: 1'b0, done: 1'b1};
                    n = n + 2'd1;
                    s = LEX_IDLE;
                    if (!is_ws(i_byte)) begin
                        res[n] = '{kind: struct_kind(i_byte), data: i_byte,
                                   lit: 1'b1, done: 1'b1};
                        n = n + 2'd1;
                    end
                end else begin
                    unique case (i_state.phase)
                        PH_SIGN: begin
                            if (is_digit(i_byte)) begin
                                ok  = 1'b1;
                                nph = (i_byte == CH_ZERO) ? PH_ZERO : PH_INT;
                            end
                        end
                        PH_ZERO, PH_INT, PH_FRAC: begin
                            priority if (is_digit(i_byte) && i_state.phase != PH_ZERO) begin
                                ok = 1'b1;
                            end else if (i_byte == CH_DOT && i_state.phase != PH_FRAC) begin
                                ok = 1'b1;
                                nph = PH_FRAC_START;
                                s.seen_dec = 1'b1;
                            end else if (i_byte == CH_E || i_byte == CH_UPPER_E) begin
                                ok = 1'b1;
                                nph = PH_EXP_START;
                            end else begin
                                ok = 1'b0;
                            end
                        end
                        PH_FRAC_START: begin
                            if (is_digit(i_byte)) begin
                                ok  = 1'b1;
                                nph = PH_FRAC;
                            end
                        end
                        PH_EXP_START: begin
                            priority if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                                ok  = 1'b1;
                                nph = PH_EXP_SIGN;
                            end else if (is_digit(i_byte)) begin
                                ok  = 1'b1;
                                nph = PH_EXP;
                            end else begin
                                ok = 1'b0;
                            end
                        end
                        default: begin
                            if (is_digit(i_byte)) begin
                                ok  = 1'b1;
                                nph = PH_EXP;
                            end
                        end
                    endcase
                    if (ok) begin
                        s.phase = nph;
                        res[n] = '{kind: s.seen_dec ? K_DECIMAL : K_INTEGER,
                                   data: i_byte, lit: 1'b1, done: 1'b0};
                        n = n + 2'd1;
                    end else begin
                        res[n] = '{kind: K_ILLEGAL, data: i_byte, lit: 1'b1, done: 1'b1};
                        n = n + 2'd1;
                        s = LEX_IDLE;
                    end
                end
            end
            MODE_KEYWORD: begin
                if (i_byte == CH_NUL) begin
                    res[n] = '{kind: K_ILLEGAL, data: CH_NUL, lit: 1'b0, done: 1'b1};
                    n = n + 2'd1;
                    s = LEX_IDLE;
                end else begin
                    miss = (i_state.kw_pos >= 3'd5) || (i_state.kw_which == KW_NONE) ||
                           (i_byte != kw_char(i_state.kw_which, i_state.kw_pos));
                    match_n = i_state.kw_match && !miss;
                    pos_n = i_state.kw_pos + 3'd1;
                    res[n] = '{kind: kw_kind, data: i_byte, lit: 1'b1, done: 1'b0};
                    n = n + 2'd1;
                    if (pos_n >= kw_len(i_state.kw_which)) begin
                        res[n] = '{kind: match_n ? kw_kind : K_ILLEGAL, data: CH_NUL,
                                   lit: 1'b0, done: 1'b1};
                        n = n + 2'd1;
                        s = LEX_IDLE;
                    end else begin
                        s.kw_pos   = pos_n;
                        s.kw_match = match_n;
                    end
                end
            end
            default: begin
                s = LEX_IDLE;
                priority if (is_struct(i_byte)) begin
                    res[n] = '{kind: struct_kind(i_byte), data: i_byte, lit: 1'b1, done: 1'b1};
                    n = n + 2'd1;
                end else if (i_byte == CH_NUL) begin
                    res[n] = '{kind: K_EOF, data: CH_NUL, lit: 1'b0, done: 1'b1};
                    n = n + 2'd1;
                end else if (i_byte == CH_QUOTE) begin
                    s.mode = MODE_STRING;
                end else if (i_byte == CH_T || i_byte == CH_F || i_byte == CH_N) begin
                    s.mode     = MODE_KEYWORD;
                    s.kw_which = (i_byte == CH_T) ? KW_TRUE :
                                 ((i_byte == CH_F) ? KW_FALSE : KW_NULL);
                    s.kw_pos   = 3'd1;
                    s.kw_match = 1'b1;
                    res[n] = '{kind: (i_byte == CH_N) ? K_NULL : K_BOOLEAN, data: i_byte,
                               lit: 1'b1, done: 1'b0};
                    n = n + 2'd1;
                end else if (is_ws(i_byte)) begin
                    s = LEX_IDLE;
                end else if (i_byte == CH_MINUS || is_digit(i_byte)) begin
                    s.mode  = MODE_NUMBER;
                    s.phase = (i_byte == CH_MINUS) ? PH_SIGN :
                              ((i_byte == CH_ZERO) ? PH_ZERO : PH_INT);
                    res[n] = '{kind: K_INTEGER, data: i_byte, lit: 1'b1, done: 1'b0};
                    n = n + 2'd1;
                end else begin
                    res[n] = '{kind: K_ILLEGAL, data: i_byte, lit: 1'b1, done: 1'b1};
                    n = n + 2'd1;
                end
            end
        endcase

        if (i_eoi) begin
            if (s.mode != MODE_IDLE) begin
                res[n] = '{kind: K_ILLEGAL, data: CH_NUL, lit: 1'b0, done: 1'b1};
                n = n + 2'd1;
            end
            s = LEX_IDLE;
        end

        o_state   = s;
        o_set.res = res;
        o_set.cnt = n;
    end

endmodule

`default_nettype wire

// ===== sv/jbt_out_buf.sv =====
// Result buffer: holds the results of one item and hands them out one per cycle while i_stall is low.
// Depends on jbt_pkg.
`default_nettype none

module jbt_out_buf
    import jbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_res_set i_set,
    input  logic     i_stall,
    output logic     o_free,
    output logic     o_valid,
    output t_result  o_result,
    output logic     o_last
);

    t_result [MaxResults-1:0] r_res;
    logic [1:0] r_cnt;
    logic [1:0] r_head;
    logic       pop;

    assign pop      = (r_cnt != 2'd0) && !i_stall;
    assign o_free   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_last   = (r_cnt == 2'd1);
    assign o_result = r_res[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (i_load) begin
            r_cnt  <= i_set.cnt;
            r_head <= 2'd0;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
            if (r_cnt != 2'd1) begin
                r_head <= r_head + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_set.res;
        end
    end

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_set.cnt != 2'd0) |=> o_valid)
        else $error("loaded results are not presented");
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && o_last && !i_load) |=> !o_valid)
        else $error("result presented after the last one of an item");
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_head <= 2'd2))
        else $error("result buffer read pointer out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/json_byte_tokenizer_unit.sv =====
// Top level of the JSON byte tokenizer: input register, lexer state and result buffer.
// Depends on jbt_pkg, jbt_lexer and jbt_out_buf.
//
// The input channel takes one byte of JSON text per item, with a flag on the final
// byte; the output channel gives token results one per cycle while i_stall is low,
// with o_last on the final result of each byte. Both channels use valid and stall; an
// item moves at a rising edge with valid high and stall low.
// An accepted byte is lexed while it sits in the input register and its results are
// loaded into the result buffer once the buffer is free; the buffer then presents
// them from its registers. A byte with several results holds the lexer while the
// buffer hands them out through its single read port. A new byte is taken in the
// cycle the last result of the previous one leaves.
// When the receiver stalls, the buffer holds its result steady and the input stall
// rises once the input register is full behind it.
// Reset (synchronous, active low) empties both registers and returns the lexer to
// idle outside any token.
`default_nettype none

module json_byte_tokenizer_unit
    import jbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_data_byte,
    output logic       o_is_literal,
    output logic       o_token_done,
    output logic       o_last
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    t_lex_state r_st;
    t_lex_state n_st;
    t_res_set   lex_set;
    t_result    out_res;
    logic       buf_free;
    logic       adv;
    logic       take;

    assign adv     = r_in_vld && buf_free;
    assign o_stall = r_in_vld && !buf_free;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_st     <= LEX_IDLE;
        end else begin
            if (take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_in_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    jbt_lexer u_lexer (
        .i_state (r_st),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_state (n_st),
        .o_set   (lex_set)
    );

    jbt_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_set    (lex_set),
        .i_stall  (i_stall),
        .o_free   (buf_free),
        .o_valid  (o_valid),
        .o_result (out_res),
        .o_last   (o_last)
    );

    assign o_token_kind = out_res.kind;
    assign o_data_byte  = out_res.data;
    assign o_is_literal = out_res.lit;
    assign o_token_done = out_res.done;

`ifndef SYNTHESIS
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_eoi) |=> (r_st.mode == MODE_IDLE))
        else $error("lexer not idle after the final byte");
`endif

endmodule

`default_nettype wire

// ===== bench/json_byte_tokenizer_unit_test.sv =====
// Self-checking bench for json_byte_tokenizer_unit: a directed table, then random JSON text.
// The bench predicts every token result on its own and checks each one as it arrives.
// Depends on jbt_pkg and the json_byte_tokenizer_unit RTL.
`default_nettype none

module json_byte_tokenizer_unit_test;
    import jbt_pkg::*;

    localparam int RandomBytes = 145;
    localparam int CalmTail = 30;
    localparam int QuietLimit = 1000;
    localparam int DrainCycles = 8;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       lit;
        logic       done;
        logic       last;
    } t_tok_res;

    typedef struct {
        logic [7:0] b;
        logic       eoi;
        logic       typed;
        t_tok_res   want;
    } t_text_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_token_kind;
    logic [7:0] o_data_byte;
    logic       o_is_literal;
    logic       o_token_done;
    logic       o_last;

    json_byte_tokenizer_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in_byte(i_in_byte),
        .i_end_of_input(i_end_of_input),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_token_kind(o_token_kind),
        .o_data_byte(o_data_byte),
        .o_is_literal(o_is_literal),
        .o_token_done(o_token_done),
        .o_last(o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Lexer state as the bench sees it.
    logic [1:0] lex_state;
    logic [2:0] num_phase;
    logic       frac_seen;
    logic [2:0] kw_idx;
    logic [1:0] kw_sel;
    logic       kw_ok;
    string      kw_word [3] = '{"true", "false", "null"};

    t_tok_res   step_out [$];
    t_tok_res   expected_tokens [$];
    t_text_item json_text [$];
    t_text_item cur_item;

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  results_seen = 0;
    int  tokens_closed = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;

    function automatic void emit(logic [3:0] kind, logic [7:0] data, logic lit, logic done);
        t_tok_res r;
        r.kind = kind;
        r.data = data;
        r.lit = lit;
        r.done = done;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void go_idle();
        lex_state = MODE_IDLE;
        num_phase = PH_SIGN;
        frac_seen = 1'b0;
        kw_idx = 3'd0;
        kw_sel = KW_TRUE;
        kw_ok = 1'b1;
    endfunction

    function automatic logic digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic logic [3:0] number_kind();
        return frac_seen ? K_DECIMAL : K_INTEGER;
    endfunction

    function automatic void start_token(logic [7:0] b);
        case (b)
            CH_LBRACE:   emit(K_LBRACE, b, 1'b1, 1'b1);
            CH_LBRACKET: emit(K_LBRACKET, b, 1'b1, 1'b1);
            CH_RBRACE:   emit(K_RBRACE, b, 1'b1, 1'b1);
            CH_RBRACKET: emit(K_RBRACKET, b, 1'b1, 1'b1);
            CH_COLON:    emit(K_COLON, b, 1'b1, 1'b1);
            CH_COMMA:    emit(K_COMMA, b, 1'b1, 1'b1);
            CH_NUL:      emit(K_EOF, 8'h00, 1'b0, 1'b1);
            CH_QUOTE:    lex_state = MODE_STRING;
            CH_T, CH_F, CH_N: begin
                lex_state = MODE_KEYWORD;
                kw_sel = (b == CH_T) ? KW_TRUE : ((b == CH_F) ? KW_FALSE : KW_NULL);
                kw_idx = 3'd1;
                kw_ok = 1'b1;
                emit(kw_sel == KW_NULL ? K_NULL : K_BOOLEAN, b, 1'b1, 1'b0);
            end
            default: begin
                if (blank(b)) begin
                end else if (b == CH_MINUS || digit(b)) begin
                    lex_state = MODE_NUMBER;
                    frac_seen = 1'b0;
                    num_phase = (b == CH_MINUS) ? PH_SIGN : ((b == CH_ZERO) ? PH_ZERO : PH_INT);
                    emit(K_INTEGER, b, 1'b1, 1'b0);
                end else begin
                    emit(K_ILLEGAL, b, 1'b1, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void number_char(logic [7:0] b);
        logic       ok;
        logic [2:0] nxt;
        logic       closes;
        ok = 1'b0;
        nxt = num_phase;
        closes = num_phase == PH_ZERO || num_phase == PH_INT ||
                 num_phase == PH_FRAC || num_phase == PH_EXP;
        if (b == CH_NUL) begin
            emit(K_ILLEGAL, 8'h00, 1'b0, 1'b1);
            go_idle();
        end else if (closes && (b == CH_COMMA || b == CH_RBRACKET || b == CH_RBRACE ||
                                blank(b))) begin
            emit(number_kind(), 8'h00, 1'b0, 1'b1);
            go_idle();
            start_token(b);
        end else begin
            case (num_phase)
                PH_SIGN: begin
                    if (digit(b)) begin
                        ok = 1'b1;
                        nxt = (b == CH_ZERO) ? PH_ZERO : PH_INT;
                    end
                end
                PH_ZERO, PH_INT, PH_FRAC: begin
                    if (digit(b) && num_phase != PH_ZERO) begin
                        ok = 1'b1;
                    end else if (b == CH_DOT && num_phase != PH_FRAC) begin
                        ok = 1'b1;
                        nxt = PH_FRAC_START;
                        frac_seen = 1'b1;
                    end else if (b == CH_E || b == CH_UPPER_E) begin
                        ok = 1'b1;
                        nxt = PH_EXP_START;
                    end
                end
                PH_FRAC_START: begin
                    if (digit(b)) begin
                        ok = 1'b1;
                        nxt = PH_FRAC;
                    end
                end
                PH_EXP_START: begin
                    if (b == CH_PLUS || b == CH_MINUS) begin
                        ok = 1'b1;
                        nxt = PH_EXP_SIGN;
                    end else if (digit(b)) begin
                        ok = 1'b1;
                        nxt = PH_EXP;
                    end
                end
                default: begin
                    if (digit(b)) begin
                        ok = 1'b1;
                        nxt = PH_EXP;
                    end
                end
            endcase
            if (ok) begin
                num_phase = nxt;
                emit(number_kind(), b, 1'b1, 1'b0);
            end else begin
                emit(K_ILLEGAL, b, 1'b1, 1'b1);
                go_idle();
            end
        end
    endfunction

    function automatic void keyword_char(logic [7:0] b);
        logic [3:0] kind;
        logic [7:0] want_char;
        kind = (kw_sel == KW_NULL) ? K_NULL : K_BOOLEAN;
        if (b == CH_NUL) begin
            emit(K_ILLEGAL, 8'h00, 1'b0, 1'b1);
            go_idle();
        end else begin
            want_char = CH_NUL;
            if (kw_sel != KW_NONE && kw_idx < kw_word[kw_sel].len())
                want_char = kw_word[kw_sel][kw_idx];
            if (kw_sel == KW_NONE || b != want_char)
                kw_ok = 1'b0;
            emit(kind, b, 1'b1, 1'b0);
            kw_idx = kw_idx + 3'd1;
            if (kw_sel == KW_NONE || kw_idx >= kw_word[kw_sel].len()) begin
                emit(kw_ok ? kind : K_ILLEGAL, 8'h00, 1'b0, 1'b1);
                go_idle();
            end
        end
    endfunction

    // Works out the results of one input byte into step_out and advances the state.
    function automatic void lex_byte(logic [7:0] b, logic eoi);
        step_out.delete();
        case (lex_state)
            MODE_STRING: begin
                if (b == CH_QUOTE) begin
                    emit(K_STRING, 8'h00, 1'b0, 1'b1);
                    go_idle();
                end else if (b == CH_NUL) begin
                    emit(K_ILLEGAL, 8'h00, 1'b0, 1'b1);
                    go_idle();
                end else begin
                    emit(K_STRING, b, 1'b1, 1'b0);
                end
            end
            MODE_NUMBER:  number_char(b);
            MODE_KEYWORD: keyword_char(b);
            default: begin
                go_idle();
                start_token(b);
            end
        endcase
        if (eoi) begin
            if (lex_state != MODE_IDLE)
                emit(K_ILLEGAL, 8'h00, 1'b0, 1'b1);
            go_idle();
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_byte(logic [7:0] b, logic eoi = 1'b0);
        t_text_item t;
        t.b = b;
        t.eoi = eoi;
        t.typed = 1'b0;
        t.want = '0;
        json_text.push_back(t);
    endfunction

    function automatic void add_typed(logic [7:0] b, logic [3:0] kind, logic [7:0] data,
                                      logic lit);
        t_text_item t;
        t.b = b;
        t.eoi = 1'b0;
        t.typed = 1'b1;
        t.want.kind = kind;
        t.want.data = data;
        t.want.lit = lit;
        t.want.done = 1'b1;
        t.want.last = 1'b1;
        json_text.push_back(t);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_struct();
        case ($urandom_range(0, 5))
            0: return CH_LBRACE;
            1: return CH_LBRACKET;
            2: return CH_RBRACE;
            3: return CH_RBRACKET;
            4: return CH_COLON;
            default: return CH_COMMA;
        endcase
    endfunction

    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return (c == CH_QUOTE) ? CH_A : c;
    endfunction

    function automatic void add_number();
        int n;
        if ($urandom_range(0, 2) == 0)
            add_byte(CH_MINUS);
        if ($urandom_range(0, 3) == 0) begin
            add_byte(CH_ZERO);
        end else begin
            add_byte(8'($urandom_range(CH_ZERO + 1, CH_NINE)));
            n = $urandom_range(0, 3);
            repeat (n) add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(0, 2) == 0) begin
            add_byte(CH_DOT);
            n = $urandom_range(1, 3);
            repeat (n) add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(0, 2) == 0) begin
            add_byte($urandom_range(0, 1) ? CH_E : CH_UPPER_E);
            case ($urandom_range(0, 2))
                0: add_byte(CH_PLUS);
                1: add_byte(CH_MINUS);
                default: ;
            endcase
            n = $urandom_range(1, 2);
            repeat (n) add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        case ($urandom_range(0, 3))
            0: add_byte(CH_COMMA);
            1: add_byte(CH_RBRACKET);
            2: add_byte(CH_RBRACE);
            default: add_byte(pick_blank());
        endcase
    endfunction

    function automatic void add_broken();
        string w;
        int    n;
        case ($urandom_range(0, 2))
            0: begin
                w = kw_word[$urandom_range(0, 2)];
                n = $urandom_range(1, w.len() - 1);
                for (int i = 0; i < n; i++) add_byte(w[i]);
                add_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: add_byte(CH_MINUS);
                    1: begin add_byte("1"); add_byte(CH_DOT); end
                    2: begin add_byte("7"); add_byte(CH_E); end
                    default: begin add_byte("3"); add_byte(CH_E); add_byte(CH_MINUS); end
                endcase
                add_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                add_byte(CH_QUOTE);
                n = $urandom_range(0, 4);
                repeat (n) add_byte(pick_text_char());
                add_byte(CH_NUL);
            end
        endcase
    endfunction

    function automatic void add_random_chunk();
        int    n;
        string w;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: add_number();
            4, 5, 6: begin
                add_byte(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) add_byte(pick_text_char());
                add_byte(CH_QUOTE);
            end
            7, 8, 9: begin
                w = kw_word[$urandom_range(0, 2)];
                for (int i = 0; i < w.len(); i++) add_byte(w[i]);
            end
            10, 11, 12, 13: add_byte(pick_struct());
            14, 15: add_byte(pick_blank());
            16, 17: begin
                n = $urandom_range(1, 3);
                repeat (n) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            default: add_broken();
        endcase
        if ($urandom_range(0, 9) == 0)
            json_text[json_text.size() - 1].eoi = 1'b1;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tok_res want;
        logic     byte_taken;
        logic     result_taken;
        byte_taken = i_rst_n && i_valid && !o_stall;
        result_taken = i_rst_n && o_valid === 1'b1 && !i_stall;
        if (byte_taken) begin
            lex_byte(cur_item.b, cur_item.eoi);
            if (cur_item.typed)
                expected_tokens.push_back(cur_item.want);
            else
                foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
            bytes_sent++;
        end
        if (result_taken) begin
            results_seen++;
            if (o_token_done)
                tokens_closed++;
            if (expected_tokens.size() == 0) begin
                $error("unexpected result: token_kind %0d data_byte %0h", o_token_kind,
                       o_data_byte);
                mismatches++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.kind, o_token_kind);
                check_field("data_byte", want.data, o_data_byte);
                check_field("is_literal", want.lit, o_is_literal);
                check_field("token_done", want.done, o_token_done);
                check_field("last", want.last, o_last);
            end
        end
        if (byte_taken || result_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QuietLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        go_idle();
        cur_item = '{b: 8'h00, eoi: 1'b0, typed: 1'b0, want: '0};

        add_typed(CH_LBRACE, K_LBRACE, CH_LBRACE, 1'b1);
        add_typed(CH_LBRACKET, K_LBRACKET, CH_LBRACKET, 1'b1);
        add_typed(CH_RBRACE, K_RBRACE, CH_RBRACE, 1'b1);
        add_typed(CH_RBRACKET, K_RBRACKET, CH_RBRACKET, 1'b1);
        add_typed(CH_COLON, K_COLON, CH_COLON, 1'b1);
        add_typed(CH_COMMA, K_COMMA, CH_COMMA, 1'b1);
        add_typed(CH_NUL, K_EOF, 8'h00, 1'b0);
        add_typed(8'hFF, K_ILLEGAL, 8'hFF, 1'b1);
        add_byte(CH_TAB);
        // A string broken by a NUL byte.
        add_byte(CH_QUOTE);
        add_byte(8'h80);
        add_byte(CH_NUL);
        // A leading zero followed by a digit.
        add_byte(CH_ZERO);
        add_byte("5");
        // A decimal point after an exponent.
        add_byte("1");
        add_byte(CH_E);
        add_byte(CH_DOT);
        // A number closed by a delimiter that is a token of its own.
        add_byte(CH_MINUS);
        add_byte("2");
        add_byte(CH_RBRACE);
        // A misspelled keyword, then the text ending inside a keyword.
        add_byte(CH_N);
        add_byte(CH_U);
        add_byte("x");
        add_byte(CH_L);
        add_byte(CH_F, 1'b1);

        while (json_text.size() < 25 + RandomBytes)
            add_random_chunk();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < json_text.size(); k++) begin
            @(negedge i_clk);
            calm = (k >= json_text.size() - CalmTail) || (k >= 80 && k < 110);
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            i_valid = 1'b1;
            i_in_byte = json_text[k].b;
            i_end_of_input = json_text[k].eoi;
            cur_item = json_text[k];
            do @(posedge i_clk); while (!(i_valid && !o_stall));
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d bytes of JSON text; checked %0d results, %0d of them closing a token.",
                 bytes_sent, results_seen, tokens_closed);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== json_byte_tokenizer_unit.f =====
sv/jbt_pkg.sv
sv/jbt_lexer.sv
sv/jbt_out_buf.sv
sv/json_byte_tokenizer_unit.sv
bench/json_byte_tokenizer_unit_test.sv
